// ----- rtl/core/stochastic_llg_drift_diffusion_top_defines.svh -----
// Assertion macros for the stochastic LLG drift/diffusion block.
// Used by the checker bound to the top level; needs clk and rst_n in scope.
`ifndef STOCHASTIC_LLG_DRIFT_DIFFUSION_TOP_DEFINES_SVH
`define STOCHASTIC_LLG_DRIFT_DIFFUSION_TOP_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define LLGDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset
`define LLGDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers reset cycles
`define LLGDD_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/llgdd_pkg.sv -----
// Package for the stochastic LLG drift/diffusion block: Q8.24 types,
// saturating arithmetic helpers, register codes. No dependencies.
`default_nettype none

package llgdd_pkg;

  typedef logic signed [31:0] q_t;

  localparam int NSTG = 8;

  // Cyclic component partners: row i uses components b = i+1 and c = i+2
  localparam int IDX_B [3] = '{1, 2, 0};
  localparam int IDX_C [3] = '{2, 0, 1};

  typedef enum logic [1:0] {
    REG_DAMPING = 2'd0,
    REG_NOISE   = 2'd1,
    REG_ITO     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [30:0] damping;
    logic [30:0] noise;
    logic        ito;
  } llgdd_cfg_t;

  // Clamp a wide signed value into Q8.24 range
  function automatic q_t sat_q(input logic signed [39:0] v);
    q_t r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q8.24 product, round half up, saturate
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] p;
    logic signed [39:0] q;
    p = a * b;
    p = p + 64'sd8388608;
    q = p[63:24];
    return sat_q(q);
  endfunction

  function automatic q_t qneg(input q_t a);
    return sat_q(-40'(a));
  endfunction

  function automatic q_t qdbl(input q_t a);
    return sat_q(40'(a) + 40'(a));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/llgdd_if.sv -----
// Request channel interfaces for the stochastic LLG drift/diffusion block.
// Depends on llgdd_pkg for the Q8.24 type.
`default_nettype none

interface llgdd_in_if;
  logic           valid;
  logic           ready;
  llgdd_pkg::q_t  mag_x;
  llgdd_pkg::q_t  mag_y;
  llgdd_pkg::q_t  mag_z;
  llgdd_pkg::q_t  field_x;
  llgdd_pkg::q_t  field_y;
  llgdd_pkg::q_t  field_z;
  modport source(output valid, mag_x, mag_y, mag_z, field_x, field_y, field_z,
                 input ready);
  modport sink(input valid, mag_x, mag_y, mag_z, field_x, field_y, field_z,
               output ready);
endinterface

interface llgdd_out_if;
  logic           valid;
  logic           ready;
  llgdd_pkg::q_t  drift_x;
  llgdd_pkg::q_t  drift_y;
  llgdd_pkg::q_t  drift_z;
  llgdd_pkg::q_t  diff_00;
  llgdd_pkg::q_t  diff_01;
  llgdd_pkg::q_t  diff_02;
  llgdd_pkg::q_t  diff_10;
  llgdd_pkg::q_t  diff_11;
  llgdd_pkg::q_t  diff_12;
  llgdd_pkg::q_t  diff_20;
  llgdd_pkg::q_t  diff_21;
  llgdd_pkg::q_t  diff_22;
  modport source(output valid, drift_x, drift_y, drift_z, diff_00, diff_01, diff_02,
                 diff_10, diff_11, diff_12, diff_20, diff_21, diff_22, input ready);
  modport sink(input valid, drift_x, drift_y, drift_z, diff_00, diff_01, diff_02,
               diff_10, diff_11, diff_12, diff_20, diff_21, diff_22, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/llgdd_cfg.sv -----
// APB register file for damping, noise strength and Ito mode.
// Depends on llgdd_pkg.
`default_nettype none

module llgdd_cfg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output llgdd_pkg::llgdd_cfg_t   cfg
);

  logic [30:0] damping_r;
  logic [30:0] noise_r;
  logic        ito_r;
  logic        wr_en;
  llgdd_pkg::reg_idx_t idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = llgdd_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  // Write registers on the access cycle; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damping_r <= 31'd1677722;
      noise_r   <= 31'd0;
      ito_r     <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        llgdd_pkg::REG_DAMPING: damping_r <= pwdata[30:0];
        llgdd_pkg::REG_NOISE:   noise_r   <= pwdata[30:0];
        llgdd_pkg::REG_ITO:     ito_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      llgdd_pkg::REG_DAMPING: prdata = {1'b0, damping_r};
      llgdd_pkg::REG_NOISE:   prdata = {1'b0, noise_r};
      llgdd_pkg::REG_ITO:     prdata = {31'd0, ito_r};
      default:                prdata = 32'd0;
    endcase
  end

  assign cfg = '{damping: damping_r, noise: noise_r, ito: ito_r};

endmodule

`default_nettype wire

// ----- rtl/core/llgdd_pipe.sv -----
// Eight-stage datapath: LLG drift, diffusion matrix and Ito correction.
// Depends on llgdd_pkg and the llgdd_in_if / llgdd_out_if interfaces.
`default_nettype none

module llgdd_pipe (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  llgdd_pkg::llgdd_cfg_t  cfg,
  llgdd_in_if.sink               in_ch,
  llgdd_out_if.source            out_ch
);

  localparam int N = llgdd_pkg::NSTG;

  logic [N-1:0]  v_r;
  logic [N-1:0]  adv;
  llgdd_pkg::q_t al;
  llgdd_pkg::q_t sg;
  llgdd_pkg::q_t m_in [3];
  llgdd_pkg::q_t h_in [3];

  // stage 1
  llgdd_pkg::q_t s1_m_r [3], s1_h_r [3], s1_sq_r [3], s1_dt_r [3];
  llgdd_pkg::q_t s1_pa_r [3], s1_pb_r [3], s1_cr_r [3];
  llgdd_pkg::q_t s1_as_r;
  // stage 2
  llgdd_pkg::q_t s2_m_r [3], s2_h_r [3], s2_sq_r [3], s2_dt_r [3];
  llgdd_pkg::q_t s2_acr_r [3], s2_am_r [3];
  logic signed [32:0] s2_pr_r [3];
  llgdd_pkg::q_t s2_as_r;
  // stage 3
  llgdd_pkg::q_t s3_m1_r [3], s3_m2_r [3], s3_bd_r [3], s3_t_r [6];
  llgdd_pkg::q_t s3_na_r [3], s3_ta_r [3];
  logic signed [32:0] s3_pr_r [3];
  // stage 4
  llgdd_pkg::q_t s4_dmp_r [3], s4_bd_r [3], s4_bo_r [6], s4_na_r [3], s4_ta_r [3];
  logic signed [32:0] s4_pr_r [3];
  // stage 5
  llgdd_pkg::q_t s5_ad_r [3], s5_bd_r [3], s5_bo_r [6], s5_na_r [3], s5_ta_r [3];
  logic signed [32:0] s5_pr_r [3];
  // stage 6
  llgdd_pkg::q_t s6_ip_r [3][8];
  llgdd_pkg::q_t s6_bd_r [3], s6_bo_r [6];
  logic signed [33:0] s6_pre_r [3];
  // stage 7
  logic signed [35:0] s7_acc_r [3];
  logic signed [33:0] s7_pre_r [3];
  llgdd_pkg::q_t s7_bd_r [3], s7_bo_r [6];
  // stage 8 (output)
  llgdd_pkg::q_t s8_dr_r [3], s8_bd_r [3], s8_bo_r [6];

  assign al = {1'b0, cfg.damping};
  assign sg = {1'b0, cfg.noise};

  assign m_in[0] = in_ch.mag_x;
  assign m_in[1] = in_ch.mag_y;
  assign m_in[2] = in_ch.mag_z;
  assign h_in[0] = in_ch.field_x;
  assign h_in[1] = in_ch.field_y;
  assign h_in[2] = in_ch.field_z;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    adv[N-1] = !v_r[N-1] || out_ch.ready;
    for (int k = N - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ch.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_ch.valid;
      for (int k = 1; k < N; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage 1: first-level products of the inputs
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 3; i++) begin
        s1_m_r[i]  <= m_in[i];
        s1_h_r[i]  <= h_in[i];
        s1_sq_r[i] <= llgdd_pkg::qmul(m_in[i], m_in[i]);
        s1_dt_r[i] <= llgdd_pkg::qmul(m_in[i], h_in[i]);
        s1_pa_r[i] <= llgdd_pkg::qmul(m_in[llgdd_pkg::IDX_C[i]], h_in[llgdd_pkg::IDX_B[i]]);
        s1_pb_r[i] <= llgdd_pkg::qmul(m_in[llgdd_pkg::IDX_B[i]], h_in[llgdd_pkg::IDX_C[i]]);
      end
      s1_cr_r[0] <= llgdd_pkg::qmul(m_in[0], m_in[1]);
      s1_cr_r[1] <= llgdd_pkg::qmul(m_in[0], m_in[2]);
      s1_cr_r[2] <= llgdd_pkg::qmul(m_in[1], m_in[2]);
      s1_as_r    <= llgdd_pkg::qmul(al, sg);
    end
  end

  // Stage 2: squared norms, dot products, precession, alpha-scaled terms
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        s2_m_r[i]   <= s1_m_r[i];
        s2_h_r[i]   <= s1_h_r[i];
        s2_sq_r[i]  <= llgdd_pkg::sat_q(40'(s1_sq_r[llgdd_pkg::IDX_B[i]])
                                        + 40'(s1_sq_r[llgdd_pkg::IDX_C[i]]));
        s2_dt_r[i]  <= llgdd_pkg::sat_q(40'(s1_dt_r[llgdd_pkg::IDX_B[i]])
                                        + 40'(s1_dt_r[llgdd_pkg::IDX_C[i]]));
        s2_pr_r[i]  <= 33'(s1_pa_r[i]) - 33'(s1_pb_r[i]);
        s2_acr_r[i] <= llgdd_pkg::qmul(al, s1_cr_r[i]);
        s2_am_r[i]  <= llgdd_pkg::qmul(s1_as_r, s1_m_r[i]);
      end
      s2_as_r <= s1_as_r;
    end
  end

  // Stage 3: damping products, diagonal diffusion, off-diagonal sums, negated and doubled alpha*sigma*m terms
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        s3_m1_r[i] <= llgdd_pkg::qmul(s2_h_r[i], s2_sq_r[i]);
        s3_m2_r[i] <= llgdd_pkg::qmul(s2_m_r[i], s2_dt_r[i]);
        s3_bd_r[i] <= llgdd_pkg::qmul(s2_as_r, s2_sq_r[i]);
        s3_na_r[i] <= llgdd_pkg::qneg(s2_am_r[i]);
        s3_ta_r[i] <= llgdd_pkg::qdbl(s2_am_r[i]);
        s3_pr_r[i] <= s2_pr_r[i];
      end
      // order: 01, 02, 10, 12, 20, 21
      s3_t_r[0] <= llgdd_pkg::sat_q(40'(s2_m_r[2]) - 40'(s2_acr_r[0]));
      s3_t_r[1] <= llgdd_pkg::sat_q(40'(s2_m_r[1]) + 40'(s2_acr_r[1]));
      s3_t_r[2] <= llgdd_pkg::sat_q(40'(s2_m_r[2]) + 40'(s2_acr_r[0]));
      s3_t_r[3] <= llgdd_pkg::sat_q(40'(s2_m_r[0]) - 40'(s2_acr_r[2]));
      s3_t_r[4] <= llgdd_pkg::sat_q(40'(s2_m_r[1]) - 40'(s2_acr_r[1]));
      s3_t_r[5] <= llgdd_pkg::sat_q(40'(s2_m_r[0]) + 40'(s2_acr_r[2]));
    end
  end

  // Stage 4: damping vector, sigma-scaled off-diagonal entries
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        s4_dmp_r[i] <= llgdd_pkg::sat_q(40'(s3_m1_r[i]) - 40'(s3_m2_r[i]));
        s4_bd_r[i]  <= s3_bd_r[i];
        s4_na_r[i]  <= s3_na_r[i];
        s4_ta_r[i]  <= s3_ta_r[i];
        s4_pr_r[i]  <= s3_pr_r[i];
      end
      for (int k = 0; k < 6; k++) begin
        s4_bo_r[k] <= llgdd_pkg::qmul(sg, s3_t_r[k]);
      end
    end
  end

  // Stage 5: alpha times damping, negate entries 02, 10, 21
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int i = 0; i < 3; i++) begin
        s5_ad_r[i] <= llgdd_pkg::qmul(al, s4_dmp_r[i]);
        s5_bd_r[i] <= s4_bd_r[i];
        s5_na_r[i] <= s4_na_r[i];
        s5_ta_r[i] <= s4_ta_r[i];
        s5_pr_r[i] <= s4_pr_r[i];
      end
      s5_bo_r[0] <= s4_bo_r[0];
      s5_bo_r[1] <= llgdd_pkg::qneg(s4_bo_r[1]);
      s5_bo_r[2] <= llgdd_pkg::qneg(s4_bo_r[2]);
      s5_bo_r[3] <= s4_bo_r[3];
      s5_bo_r[4] <= s4_bo_r[4];
      s5_bo_r[5] <= llgdd_pkg::qneg(s4_bo_r[5]);
    end
  end

  // Stage 6: Ito products b[k][j] * db[i][j]/dm_k, drift sum before correction
  llgdd_pkg::q_t b00, b01, b02, b10, b11, b12, b20, b21, b22, ns;
  assign b00 = s5_bd_r[0];
  assign b11 = s5_bd_r[1];
  assign b22 = s5_bd_r[2];
  assign b01 = s5_bo_r[0];
  assign b02 = s5_bo_r[1];
  assign b10 = s5_bo_r[2];
  assign b12 = s5_bo_r[3];
  assign b20 = s5_bo_r[4];
  assign b21 = s5_bo_r[5];
  assign ns  = -sg;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int i = 0; i < 3; i++) begin
        s6_pre_r[i] <= 34'(s5_pr_r[i]) + 34'(s5_ad_r[i]);
        s6_bd_r[i]  <= s5_bd_r[i];
      end
      for (int k = 0; k < 6; k++) begin
        s6_bo_r[k] <= s5_bo_r[k];
      end
      // x row
      s6_ip_r[0][0] <= llgdd_pkg::qmul(b10, s5_ta_r[1]);
      s6_ip_r[0][1] <= llgdd_pkg::qmul(b20, s5_ta_r[2]);
      s6_ip_r[0][2] <= llgdd_pkg::qmul(b01, s5_na_r[1]);
      s6_ip_r[0][3] <= llgdd_pkg::qmul(b11, s5_na_r[0]);
      s6_ip_r[0][4] <= llgdd_pkg::qmul(b21, sg);
      s6_ip_r[0][5] <= llgdd_pkg::qmul(b02, s5_na_r[2]);
      s6_ip_r[0][6] <= llgdd_pkg::qmul(b12, ns);
      s6_ip_r[0][7] <= llgdd_pkg::qmul(b22, s5_na_r[0]);
      // y row
      s6_ip_r[1][0] <= llgdd_pkg::qmul(b00, s5_na_r[1]);
      s6_ip_r[1][1] <= llgdd_pkg::qmul(b10, s5_na_r[0]);
      s6_ip_r[1][2] <= llgdd_pkg::qmul(b20, ns);
      s6_ip_r[1][3] <= llgdd_pkg::qmul(b01, s5_ta_r[0]);
      s6_ip_r[1][4] <= llgdd_pkg::qmul(b21, s5_ta_r[2]);
      s6_ip_r[1][5] <= llgdd_pkg::qmul(b02, sg);
      s6_ip_r[1][6] <= llgdd_pkg::qmul(b12, s5_na_r[2]);
      s6_ip_r[1][7] <= llgdd_pkg::qmul(b22, s5_na_r[1]);
      // z row
      s6_ip_r[2][0] <= llgdd_pkg::qmul(b00, s5_na_r[2]);
      s6_ip_r[2][1] <= llgdd_pkg::qmul(b10, sg);
      s6_ip_r[2][2] <= llgdd_pkg::qmul(b20, s5_na_r[0]);
      s6_ip_r[2][3] <= llgdd_pkg::qmul(b01, ns);
      s6_ip_r[2][4] <= llgdd_pkg::qmul(b11, s5_na_r[2]);
      s6_ip_r[2][5] <= llgdd_pkg::qmul(b21, s5_na_r[1]);
      s6_ip_r[2][6] <= llgdd_pkg::qmul(b02, s5_ta_r[0]);
      s6_ip_r[2][7] <= llgdd_pkg::qmul(b12, s5_ta_r[1]);
    end
  end

  // Stage 7: sum the Ito products per row
  logic signed [35:0] acc_nxt [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_nxt[i] = '0;
      for (int j = 0; j < 8; j++) begin
        acc_nxt[i] = acc_nxt[i] + 36'(s6_ip_r[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int i = 0; i < 3; i++) begin
        s7_acc_r[i] <= acc_nxt[i];
        s7_pre_r[i] <= s6_pre_r[i];
        s7_bd_r[i]  <= s6_bd_r[i];
      end
      for (int k = 0; k < 6; k++) begin
        s7_bo_r[k] <= s6_bo_r[k];
      end
    end
  end

  // Stage 8: halve the correction, add in Ito mode, saturate
  logic signed [35:0] half [3];
  logic signed [36:0] tot [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      half[i] = (s7_acc_r[i] + 36'sd1) >>> 1;
      tot[i]  = cfg.ito ? 37'(s7_pre_r[i]) + 37'(half[i]) : 37'(s7_pre_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      for (int i = 0; i < 3; i++) begin
        s8_dr_r[i] <= llgdd_pkg::sat_q(40'(tot[i]));
        s8_bd_r[i] <= s7_bd_r[i];
      end
      for (int k = 0; k < 6; k++) begin
        s8_bo_r[k] <= s7_bo_r[k];
      end
    end
  end

  assign out_ch.valid   = v_r[N-1];
  assign out_ch.drift_x = s8_dr_r[0];
  assign out_ch.drift_y = s8_dr_r[1];
  assign out_ch.drift_z = s8_dr_r[2];
  assign out_ch.diff_00 = s8_bd_r[0];
  assign out_ch.diff_01 = s8_bo_r[0];
  assign out_ch.diff_02 = s8_bo_r[1];
  assign out_ch.diff_10 = s8_bo_r[2];
  assign out_ch.diff_11 = s8_bd_r[1];
  assign out_ch.diff_12 = s8_bo_r[3];
  assign out_ch.diff_20 = s8_bo_r[4];
  assign out_ch.diff_21 = s8_bo_r[5];
  assign out_ch.diff_22 = s8_bd_r[2];

endmodule

`default_nettype wire

// ----- rtl/core/stochastic_llg_drift_diffusion_top.sv -----
// Stochastic LLG drift/diffusion evaluator, top level.
// Depends on llgdd_pkg, llgdd_in_if/llgdd_out_if, llgdd_cfg, llgdd_pipe.
//
// Usage:
//   in_ch carries one magnetization and one reduced field vector (Q8.24) per
//   request; out_ch returns the drift vector and the 3x3 diffusion matrix.
//   Both are valid/ready channels; a request moves when valid and ready are
//   high at a rising edge. The APB port sets damping (0x0), noise strength
//   (0x4) and Ito mode (0x8); write it only while no request is in flight.
//   A request accepted on in_ch passes through eight register stages
//   (products, norms and alpha terms, damping products, sigma scaling,
//   alpha*damping, Ito products, row sum, final add) to out_ch.
//   Throughput: one request per cycle while out_ch.ready stays high.
//   Stall: when the receiver holds ready low, the output holds its request
//   and empty stages behind it still fill, so in_ch.ready drops only once
//   every stage holds a request.
//   Reset (rst_n low, synchronous): all stages empty, registers back to
//   damping 0.1, noise 0, Stratonovich mode.
`default_nettype none

module stochastic_llg_drift_diffusion_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  llgdd_in_if.sink          in_ch,
  llgdd_out_if.source       out_ch,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  llgdd_pkg::llgdd_cfg_t cfg;

  // Configuration registers
  llgdd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Datapath
  llgdd_pipe u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ----- rtl/core/llgdd_checker.sv -----
// Port-level checker for the stochastic LLG drift/diffusion top level.
// Depends on stochastic_llg_drift_diffusion_top_defines.svh; bound below.
`default_nettype none
`include "stochastic_llg_drift_diffusion_top_defines.svh"

module llgdd_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  // Hold an offered result until taken
  `LLGDD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out request dropped")

  // Never back-pressure the input while the receiver takes results
  `LLGDD_ASSERT_NOW(a_no_block, out_ready, in_ready, "input blocked with output ready")

  // Pipeline empties on reset
  `LLGDD_ASSERT_RST(a_rst_empty, !rst_n, !out_valid, "output valid after reset")

endmodule

bind stochastic_llg_drift_diffusion_top llgdd_checker u_llgdd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for stochastic_llg_drift_diffusion_top.
// Drives requests with random gaps and back-pressure, and predicts drift and diffusion in Q8.24.
// Depends on llgdd_pkg, llgdd_in_if/llgdd_out_if and the RTL top level.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    llgdd_pkg::q_t mag [3];
    llgdd_pkg::q_t fld [3];
  } llg_req_t;

  typedef struct {
    llgdd_pkg::q_t drift [3];
    llgdd_pkg::q_t diff [9];
  } llg_res_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  llgdd_in_if  in_ch ();
  llgdd_out_if out_ch ();

  stochastic_llg_drift_diffusion_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the register file
  longint     alpha_q;
  longint     sigma_q;
  bit         ito_on;

  llg_req_t   pending_q [$];
  llg_res_t   expected_q [$];
  int         src_idle_pct;
  int         snk_idle_pct;
  bit         req_taken;
  int         fail_cnt;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Saturating Q8.24 arithmetic
  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qm(longint a, longint b);
    longint p;
    p = a * b + 64'sd8388608;
    return sat32(p >>> 24);
  endfunction

  function automatic longint drift_sum(longint al, longint a, longint b, longint c,
                                       longint ha, longint hb, longint hc);
    longint sq, dot, damp;
    sq = sat32(qm(b, b) + qm(c, c));
    dot = sat32(qm(b, hb) + qm(c, hc));
    damp = sat32(qm(ha, sq) - qm(a, dot));
    return qm(c, hb) - qm(b, hc) + qm(al, damp);
  endfunction

  function automatic llg_res_t predict_llg(llg_req_t r);
    llg_res_t res;
    longint x, y, z, hx, hy, hz, al, s, as_, ax, ay, az, nax, nay, naz;
    longint tax, tay, taz, ns, acc;
    longint dr [3];
    longint b [3][3];
    longint d [3][3][3];
    x = r.mag[0]; y = r.mag[1]; z = r.mag[2];
    hx = r.fld[0]; hy = r.fld[1]; hz = r.fld[2];
    al = alpha_q; s = sigma_q;
    dr[0] = drift_sum(al, x, y, z, hx, hy, hz);
    dr[1] = drift_sum(al, y, z, x, hy, hz, hx);
    dr[2] = drift_sum(al, z, x, y, hz, hx, hy);
    as_ = qm(al, s);
    b[0][0] = qm(as_, sat32(qm(y, y) + qm(z, z)));
    b[0][1] = qm(s, sat32(z - qm(al, qm(x, y))));
    b[0][2] = sat32(-qm(s, sat32(y + qm(al, qm(x, z)))));
    b[1][0] = sat32(-qm(s, sat32(z + qm(al, qm(x, y)))));
    b[1][1] = qm(as_, sat32(qm(x, x) + qm(z, z)));
    b[1][2] = qm(s, sat32(x - qm(al, qm(y, z))));
    b[2][0] = qm(s, sat32(y - qm(al, qm(x, z))));
    b[2][1] = sat32(-qm(s, sat32(x + qm(al, qm(y, z)))));
    b[2][2] = qm(as_, sat32(qm(x, x) + qm(y, y)));
    // Ito correction from the exact partial derivatives of b
    if (ito_on) begin
      ax = qm(as_, x); ay = qm(as_, y); az = qm(as_, z);
      nax = sat32(-ax); nay = sat32(-ay); naz = sat32(-az);
      tax = sat32(2 * ax); tay = sat32(2 * ay); taz = sat32(2 * az);
      ns = sat32(-s);
      d[0][0][0] = 0;   d[0][0][1] = tay; d[0][0][2] = taz;
      d[0][1][0] = nay; d[0][1][1] = nax; d[0][1][2] = s;
      d[0][2][0] = naz; d[0][2][1] = ns;  d[0][2][2] = nax;
      d[1][0][0] = nay; d[1][0][1] = nax; d[1][0][2] = ns;
      d[1][1][0] = tax; d[1][1][1] = 0;   d[1][1][2] = taz;
      d[1][2][0] = s;   d[1][2][1] = naz; d[1][2][2] = nay;
      d[2][0][0] = naz; d[2][0][1] = s;   d[2][0][2] = nax;
      d[2][1][0] = ns;  d[2][1][1] = naz; d[2][1][2] = nay;
      d[2][2][0] = tax; d[2][2][1] = tay; d[2][2][2] = 0;
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++)
            acc += qm(b[k][j], d[i][j][k]);
        dr[i] += (acc + 1) >>> 1;
      end
    end
    for (int i = 0; i < 3; i++) res.drift[i] = llgdd_pkg::q_t'(sat32(dr[i]));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) res.diff[i * 3 + j] = llgdd_pkg::q_t'(b[i][j]);
    return res;
  endfunction

  // Record each accepted request and its expected result
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_q.push_back(predict_llg(pending_q[0]));
      void'(pending_q.pop_front());
      req_taken <= 1'b1;
    end else begin
      req_taken <= 1'b0;
    end
  end

  // Drive requests at the falling edge; hold an offered request until taken
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || req_taken)) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        in_ch.valid   = 1'b1;
        in_ch.mag_x   = pending_q[0].mag[0];
        in_ch.mag_y   = pending_q[0].mag[1];
        in_ch.mag_z   = pending_q[0].mag[2];
        in_ch.field_x = pending_q[0].fld[0];
        in_ch.field_y = pending_q[0].fld[1];
        in_ch.field_z = pending_q[0].fld[2];
      end else begin
        in_ch.valid = 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    if (rst_n) out_ch.ready = ($urandom_range(99) >= snk_idle_pct);
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    llg_res_t want;
    llgdd_pkg::q_t got [12];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.drift_x, out_ch.drift_y, out_ch.drift_z,
              out_ch.diff_00, out_ch.diff_01, out_ch.diff_02,
              out_ch.diff_10, out_ch.diff_11, out_ch.diff_12,
              out_ch.diff_20, out_ch.diff_21, out_ch.diff_22};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, drift_x %h", $realtime, out_ch.drift_x);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        for (int f = 0; f < 12; f++) begin
          if (got[f] !== (f < 3 ? want.drift[f] : want.diff[f - 3])) begin
            $display("%0t: field %0d mismatch, expected %h, actual %h", $realtime, f,
                     (f < 3 ? want.drift[f] : want.diff[f - 3]), got[f]);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Byte address of a register
  function automatic logic [3:0] reg_addr(llgdd_pkg::reg_idx_t r);
    return {r, 2'b00};
  endfunction

  // APB write through the setup and access phases; mirror the masked value into the shadow registers
  task automatic apb_write(logic [3:0] addr, logic [31:0] data);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (addr)
      reg_addr(llgdd_pkg::REG_DAMPING): alpha_q = longint'(data[30:0]);
      reg_addr(llgdd_pkg::REG_NOISE):   sigma_q = longint'(data[30:0]);
      reg_addr(llgdd_pkg::REG_ITO):     ito_on = data[0];
      default: ;
    endcase
  endtask

  // Hold until the block is drained, then let the pipeline settle
  task automatic wait_idle();
    while (pending_q.size() != 0 || in_ch.valid || expected_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic llgdd_pkg::q_t rand_comp(int kind);
    case (kind)
      0: return llgdd_pkg::q_t'($urandom);
      1: return llgdd_pkg::q_t'(int'($urandom_range(33554432)) - 16777216);
      default: return llgdd_pkg::q_t'(int'($urandom_range(134217728)) - 67108864);
    endcase
  endfunction

  task automatic add_req(llgdd_pkg::q_t mx, llgdd_pkg::q_t my, llgdd_pkg::q_t mz,
                         llgdd_pkg::q_t fx, llgdd_pkg::q_t fy, llgdd_pkg::q_t fz);
    llg_req_t r;
    r.mag = '{mx, my, mz};
    r.fld = '{fx, fy, fz};
    pending_q.push_back(r);
  endtask

  task automatic add_random(int n);
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = ($urandom_range(9) < 3) ? 0 : 1;
      add_req(rand_comp(kind), rand_comp(kind), rand_comp(kind),
              rand_comp(kind == 0 ? 0 : 2), rand_comp(kind == 0 ? 0 : 2),
              rand_comp(kind == 0 ? 0 : 2));
    end
  endtask

  localparam llgdd_pkg::q_t QMAX = 32'sh7FFFFFFF;
  localparam llgdd_pkg::q_t QMIN = 32'sh80000000;
  localparam llgdd_pkg::q_t QONE = 32'sh01000000;

  initial begin
    logic [31:0] alpha_set [8];
    logic [31:0] sigma_set [8];
    rst_n = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mag_x = '0; in_ch.mag_y = '0; in_ch.mag_z = '0;
    in_ch.field_x = '0; in_ch.field_y = '0; in_ch.field_z = '0;
    out_ch.ready = 1'b0;
    alpha_q = 1677722; sigma_q = 0; ito_on = 1'b0;
    src_idle_pct = 0; snk_idle_pct = 0; fail_cnt = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed requests under reset settings, then with noise and Ito on
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        apb_write(reg_addr(llgdd_pkg::REG_NOISE), 32'h80800000);
        apb_write(reg_addr(llgdd_pkg::REG_ITO), 32'hFFFFFFFF);
        apb_write(4'hC, 32'h12345678);
      end
      add_req(0, 0, 0, 0, 0, 0);
      add_req(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX);
      add_req(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN);
      add_req(QMAX, QMIN, QMAX, QMIN, QMAX, QMIN);
      add_req(QONE, 0, 0, 0, 0, QONE);
      add_req(0, QONE, 0, QONE, 0, 0);
      add_req(0, 0, QONE, 0, QONE, 0);
      add_req(-QONE, QONE, -QONE, QMAX, QMIN, QONE);
      add_req(32'sh00B504F3, 32'sh00B504F3, 0, 0, 0, 32'sh10000000);
      add_req(QMIN, 0, QONE, QMAX, -QONE, 0);
      wait_idle();
    end

    // Random phases over a sweep of settings and idling patterns
    alpha_set = '{32'hFFFFFFFF, 0, 32'h0019999A, 32'h01000000,
                  32'h00200000, 32'h7FFFFFFF, 32'h00080000, 32'h00400000};
    sigma_set = '{32'h7FFFFFFF, 32'h01000000, 0, 32'h00100000,
                  32'h00800000, 32'h7FFFFFFF, 32'h02000000, 32'h00040000};
    for (int ph = 0; ph < 8; ph++) begin
      apb_write(reg_addr(llgdd_pkg::REG_DAMPING),
                (ph > 5) ? $urandom & 32'h00FFFFFF : alpha_set[ph]);
      apb_write(reg_addr(llgdd_pkg::REG_NOISE),
                (ph > 5) ? $urandom & 32'h00FFFFFF : sigma_set[ph]);
      apb_write(reg_addr(llgdd_pkg::REG_ITO), 32'(ph % 2));
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
        1: begin src_idle_pct = 72; snk_idle_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_idle_pct = 72; end
        default: begin src_idle_pct = 24; snk_idle_pct = 24; end
      endcase
      add_random(242);
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("stochastic_llg_drift_diffusion_top regression: pass");
    end else begin
      $display("stochastic_llg_drift_diffusion_top regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("stochastic_llg_drift_diffusion_top regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
